// ===== src/art_pkg.sv =====
// Shared types and constants for the address region table.
package art_pkg;

    localparam int NUM_REGIONS_DEF = 8;
    localparam int PAGE_BITS_DEF   = 12;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 33;
    localparam int PERM_W   = 3;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;

    // Function codes of a request.
    localparam logic FUNC_DEFINE = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_STACK_TOP = 1'b0;
    localparam logic CFG_LOADING   = 1'b1;

    localparam logic [ADDR_W-1:0] STACK_TOP_RST = 32'h8000_0000;

    typedef struct packed {
        logic [PERM_W-1:0] perm;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic def_check;
        logic def_write;
        logic scan;
        logic load_out;
    } art_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic def_ok;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } art_stat_t;

endpackage

// ===== src/art_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/art_ctrl.sv =====
// Sequencing state machine for define and lookup requests.
module art_ctrl import art_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  art_stat_t stat,
    output art_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEF_CHECK,
        S_DEF_WRITE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_DEF_CHECK;
                end
            end
            S_DEF_CHECK:
            begin
                // The captured function is only known from the cycle after the transfer.
                if (stat.is_lookup)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.def_check = 1'b1;
                    state_next    = stat.def_ok ? S_DEF_WRITE : S_RESP;
                end
            end
            S_DEF_WRITE:
            begin
                cmd.def_write = 1'b1;
                state_next    = S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

// ===== src/art_dp.sv =====
// Datapath: configuration, region memory, define arithmetic, lookup compare and output register.
module art_dp import art_pkg::*; #(
    parameter int NUM_REGIONS = NUM_REGIONS_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                func,
    input  logic [ADDR_W-1:0]   address,
    input  logic [ADDR_W-1:0]   length,
    input  logic                want_read,
    input  logic                want_write,
    input  logic                want_exec,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [STATUS_W-1:0] status,
    output logic                hit,
    output logic [INDEX_W-1:0]  region_index,
    output logic [ADDR_W-1:0]   region_base,
    output logic [SIZE_W-1:0]   region_size,
    output logic                can_read,
    output logic                can_write,
    output logic                can_exec,
    input  art_cmd_t            cmd,
    output art_stat_t           stat
);

    localparam int CW = $clog2(NUM_REGIONS + 1);
    localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam logic [SIZE_W-1:0] OFF_MASK = SIZE_W'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [CW-1:0] CNT_MAX = CW'(NUM_REGIONS);

    // Configuration registers.
    logic [ADDR_W-1:0] stack_top_reg;
    logic              loading_reg;

    // Captured request.
    logic              func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [PERM_W-1:0] perm_reg;

    // Table state and scan pointers.
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     idx_reg;
    logic              cmp_vld_reg;
    logic [CW-1:0]     cmp_idx_reg;
    logic [SIZE_W-1:0] size_raw_reg;

    // Pending result and output register.
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_hit_reg;
    logic [INDEX_W-1:0]  res_index_reg;
    logic [ADDR_W-1:0]   res_base_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic [PERM_W-1:0]   res_perm_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_hit_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [ADDR_W-1:0]   out_base_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic [PERM_W-1:0]   out_perm_reg;

    logic              over_top;
    logic              table_full;
    logic [SIZE_W-1:0] size_round;
    entry_t            wr_entry;
    entry_t            rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic [SIZE_W:0]   diff;
    logic              hit_now;
    logic              issue;

    assign over_top   = ({1'b0, addr_reg} + {1'b0, len_reg}) > {1'b0, stack_top_reg};
    assign table_full = (cnt_reg == CNT_MAX);
    assign size_round = (size_raw_reg + OFF_MASK) & ~OFF_MASK;

    assign wr_entry.perm = perm_reg;
    assign wr_entry.size = size_round;
    assign wr_entry.base = addr_reg & ~OFF_MASK[ADDR_W-1:0];

    assign rd_entry = entry_t'(rd_data);

    // A borrow out of the subtraction means the address lies below the base.
    assign diff    = {2'b00, addr_reg} - {2'b00, rd_entry.base};
    assign hit_now = cmp_vld_reg && !diff[SIZE_W] && (diff[SIZE_W-1:0] < rd_entry.size);
    assign issue   = cmd.scan && (idx_reg < cnt_reg) && !hit_now;

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_REGIONS)
    ) u_region_ram (
        .clk   (clk),
        .we    (cmd.def_write),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg <= STACK_TOP_RST;
            loading_reg   <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STACK_TOP: stack_top_reg <= cfg_data[ADDR_W-1:0];
                    CFG_LOADING:   loading_reg   <= cfg_data[0];
                    default:       loading_reg   <= loading_reg;
                endcase
            end
            if (cmd.def_write)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            cmp_vld_reg <= issue;
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
        if (cmd.capture)
        begin
            func_reg       <= func;
            addr_reg       <= address;
            len_reg        <= length;
            perm_reg       <= {want_exec, want_write, want_read};
            res_status_reg <= STATUS_OK;
            res_hit_reg    <= 1'b0;
            res_index_reg  <= '0;
            res_base_reg   <= '0;
            res_size_reg   <= '0;
            res_perm_reg   <= '0;
        end
        if (cmd.def_check)
        begin
            // The stack top check takes priority over the full check.
            priority if (over_top)
            begin
                res_status_reg <= STATUS_BEYOND;
            end
            else if (table_full)
            begin
                res_status_reg <= STATUS_FULL;
            end
            else
            begin
                res_status_reg <= STATUS_OK;
            end
            size_raw_reg <= {1'b0, len_reg} + {1'b0, addr_reg & OFF_MASK[ADDR_W-1:0]};
        end
        if (cmd.scan && hit_now)
        begin
            res_hit_reg   <= 1'b1;
            res_index_reg <= INDEX_W'(cmp_idx_reg);
            res_base_reg  <= rd_entry.base;
            res_size_reg  <= rd_entry.size;
            res_perm_reg  <= rd_entry.perm | {1'b0, loading_reg, 1'b0};
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_hit_reg    <= res_hit_reg;
            out_index_reg  <= res_index_reg;
            out_base_reg   <= res_base_reg;
            out_size_reg   <= res_size_reg;
            out_perm_reg   <= res_perm_reg;
        end
    end

    assign stat.is_lookup = (func_reg == FUNC_LOOKUP);
    assign stat.def_ok    = !over_top && !table_full;
    assign stat.scan_hit  = hit_now;
    assign stat.scan_end  = !cmp_vld_reg && (idx_reg >= cnt_reg);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid    = rsp_valid_reg;
    assign status       = out_status_reg;
    assign hit          = out_hit_reg;
    assign region_index = out_index_reg;
    assign region_base  = out_base_reg;
    assign region_size  = out_size_reg;
    assign can_read     = out_perm_reg[0];
    assign can_write    = out_perm_reg[1];
    assign can_exec     = out_perm_reg[2];

endmodule

// ===== src/address_region_table.sv =====
// Region table of an address space. A define request that passes its checks goes from its
// transfer to its result through capture, bounds and fill check, page rounding with the
// table write, and the result register; a rejected define skips the table write. A lookup
// passes a dispatch step, then reads one stored region per cycle in insertion order from the
// region memory, with a registered read and a compare for each region, and stops at the
// first hit or after the last stored region. A new request is taken once the previous one
// has reached the result register, even while that result still waits for its transfer; a
// result that finds the result register still occupied waits until it is free. No clearing
// pass follows reset; entries beyond the region count are never used by a lookup.
module address_region_table import art_pkg::*; #(
    parameter int NUM_REGIONS = NUM_REGIONS_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                func,
    input  logic [ADDR_W-1:0]   address,
    input  logic [ADDR_W-1:0]   length,
    input  logic                want_read,
    input  logic                want_write,
    input  logic                want_exec,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic                hit,
    output logic [INDEX_W-1:0]  region_index,
    output logic [ADDR_W-1:0]   region_base,
    output logic [SIZE_W-1:0]   region_size,
    output logic                can_read,
    output logic                can_write,
    output logic                can_exec
);

    art_cmd_t  cmd;
    art_stat_t stat;

    art_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    art_dp #(
        .NUM_REGIONS (NUM_REGIONS),
        .PAGE_BITS   (PAGE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .address      (address),
        .length       (length),
        .want_read    (want_read),
        .want_write   (want_write),
        .want_exec    (want_exec),
        .rsp_ready    (rsp_ready),
        .rsp_valid    (rsp_valid),
        .status       (status),
        .hit          (hit),
        .region_index (region_index),
        .region_base  (region_base),
        .region_size  (region_size),
        .can_read     (can_read),
        .can_write    (can_write),
        .can_exec     (can_exec),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
